[rtl/plfc_pkg.sv]
// plfc_pkg: shared constants, opcodes and control/status structs for the
// priority led flash controller; no dependencies
package plfc_pkg;

  localparam int LED_NUM   = 3;
  localparam int LED_IDX_W = (LED_NUM > 1) ? $clog2(LED_NUM) : 1;

  localparam logic [15:0]        FOREVER_CODE = 16'hFFFF;
  localparam logic [LED_NUM-1:0] MASK_RESET   = 3'b100;

  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_FLASH = 2'd1;
  localparam logic [1:0] OP_OFF   = 2'd2;

  localparam int TIME_W    = 32;
  localparam int HALF_W    = 16;
  localparam int DIV_CNT_W = 6;
  localparam logic [DIV_CNT_W-1:0] DIV_STEPS_LONG  = 6'd32;
  localparam logic [DIV_CNT_W-1:0] DIV_STEPS_SHORT = 6'd16;
  localparam int SPAN_W    = 25;

  typedef struct packed {
    logic tick;
    logic flash;
    logic off;
    logic prep;
    logic mark_dark;
    logic div_mod;
    logic div_quo;
    logic mark_quo;
    logic next_led;
    logic emit;
  } plfc_cmd_t;

  typedef struct packed {
    logic dark;
    logic gt_span;
    logic div_done;
    logic last_led;
    logic out_free;
  } plfc_sts_t;

endpackage

[rtl/plfc_div.sv]
// plfc_div: serial restoring divider, 32-bit dividend by 16-bit divisor,
// one quotient bit per cycle; depends on plfc_pkg
module plfc_div (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic                               short_op,
  input  logic [plfc_pkg::TIME_W-1:0]        dividend,
  input  logic [plfc_pkg::HALF_W-1:0]        divisor,
  output logic                               busy,
  output logic                               done,
  output logic [plfc_pkg::TIME_W-1:0]        quotient,
  output logic [plfc_pkg::HALF_W-1:0]        remainder
);

  logic [plfc_pkg::TIME_W-1:0]    quo_r;
  logic [plfc_pkg::HALF_W-1:0]    rem_r;
  logic [plfc_pkg::HALF_W-1:0]    dsr_r;
  logic [plfc_pkg::DIV_CNT_W-1:0] cnt_r;
  logic                           busy_r;
  logic                           done_r;

  logic [plfc_pkg::HALF_W:0] trial;
  logic [plfc_pkg::HALF_W:0] diff;
  logic                      ge;

  assign trial = {rem_r, quo_r[plfc_pkg::TIME_W-1]};
  assign ge    = trial >= {1'b0, dsr_r};
  assign diff  = trial - {1'b0, dsr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= short_op ? plfc_pkg::DIV_STEPS_SHORT : plfc_pkg::DIV_STEPS_LONG;
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == plfc_pkg::DIV_CNT_W'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  // done rises once the last step has landed in the result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r <= 1'b0;
    end else begin
      done_r <= busy_r && (cnt_r == plfc_pkg::DIV_CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dsr_r <= divisor;
    end else if (busy_r) begin
      rem_r <= ge ? diff[plfc_pkg::HALF_W-1:0] : trial[plfc_pkg::HALF_W-1:0];
      quo_r <= {quo_r[plfc_pkg::TIME_W-2:0], ge};
    end
  end

  assign busy      = busy_r;
  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

[rtl/plfc_dp.sv]
// plfc_dp: per-led settings, time counter, pattern evaluation and result
// register; depends on plfc_pkg and plfc_div
module plfc_dp (
  input  logic                         clk,
  input  logic                         rst_n,
  input  plfc_pkg::plfc_cmd_t          cmd,
  output plfc_pkg::plfc_sts_t          sts,
  input  logic [3:0]                   in_led_select,
  input  logic [7:0]                   in_priority_req,
  input  logic [15:0]                  in_period,
  input  logic [15:0]                  in_on_width,
  input  logic [7:0]                   in_flash_count,
  input  logic [15:0]                  in_hold_time,
  input  logic                         cfg_wr_en,
  input  logic [plfc_pkg::LED_NUM-1:0] cfg_wr_data,
  input  logic                         out_stall,
  output logic                         out_valid,
  output logic [plfc_pkg::LED_NUM-1:0] out_pin_levels
);

  logic [plfc_pkg::TIME_W-1:0] time_now_r;
  logic [plfc_pkg::TIME_W-1:0] start_r  [plfc_pkg::LED_NUM];
  logic [15:0]                 period_r [plfc_pkg::LED_NUM];
  logic [15:0]                 width_r  [plfc_pkg::LED_NUM];
  logic [15:0]                 hold_r   [plfc_pkg::LED_NUM];
  logic [7:0]                  prio_r   [plfc_pkg::LED_NUM];
  logic [7:0]                  count_r  [plfc_pkg::LED_NUM];
  logic [plfc_pkg::LED_NUM-1:0] mask_r;

  logic [plfc_pkg::LED_IDX_W-1:0] idx_r;
  logic [plfc_pkg::TIME_W-1:0]    elapsed_r;
  logic [plfc_pkg::SPAN_W-1:0]    span_r;
  logic                           dark_r;
  logic [plfc_pkg::LED_NUM-1:0]   levels_r;
  logic                           out_valid_r;
  logic [plfc_pkg::LED_NUM-1:0]   out_levels_r;

  logic                           sel_ok;
  logic [plfc_pkg::LED_IDX_W-1:0] sel_idx;
  logic                           prio_ok;

  logic [plfc_pkg::TIME_W-1:0] cur_elapsed;
  logic                        hold_dead;
  logic                        zero_cfg;
  logic [8:0]                  odd_mult;
  logic [plfc_pkg::SPAN_W-1:0] span_prod;

  logic                        div_start;
  logic                        div_busy;
  logic                        div_done;
  logic [plfc_pkg::TIME_W-1:0] div_dividend;
  logic [plfc_pkg::HALF_W-1:0] div_divisor;
  logic [plfc_pkg::TIME_W-1:0] div_quo;
  logic [plfc_pkg::HALF_W-1:0] div_rem;

  assign sel_ok  = in_led_select < 4'(plfc_pkg::LED_NUM);
  assign sel_idx = in_led_select[plfc_pkg::LED_IDX_W-1:0];
  assign prio_ok = sel_ok && (in_priority_req >= prio_r[sel_idx]);

  // settings store
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < plfc_pkg::LED_NUM; i++) begin
        start_r[i]  <= '0;
        period_r[i] <= '0;
        width_r[i]  <= '0;
        hold_r[i]   <= '0;
        prio_r[i]   <= '0;
        count_r[i]  <= '0;
      end
    end else if (cmd.flash && prio_ok) begin
      start_r[sel_idx]  <= time_now_r;
      period_r[sel_idx] <= in_period;
      width_r[sel_idx]  <= in_on_width;
      hold_r[sel_idx]   <= in_hold_time;
      prio_r[sel_idx]   <= in_priority_req;
      count_r[sel_idx]  <= in_flash_count;
    end else if (cmd.off && sel_ok) begin
      start_r[sel_idx]  <= '0;
      period_r[sel_idx] <= '0;
      width_r[sel_idx]  <= '0;
      hold_r[sel_idx]   <= '0;
      prio_r[sel_idx]   <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_now_r <= '0;
      mask_r     <= plfc_pkg::MASK_RESET;
    end else begin
      if (cmd.tick) begin
        time_now_r <= time_now_r + 1'b1;
      end
      if (cfg_wr_en) begin
        mask_r <= cfg_wr_data;
      end
    end
  end

  // per-led front checks
  assign cur_elapsed = time_now_r - start_r[idx_r];
  assign hold_dead   = (hold_r[idx_r] != plfc_pkg::FOREVER_CODE) &&
                       (cur_elapsed > {16'b0, hold_r[idx_r]});
  assign zero_cfg    = (count_r[idx_r] == 8'd0) || (period_r[idx_r] == 16'd0) ||
                       (width_r[idx_r] == 16'd0);
  assign odd_mult    = {count_r[idx_r], 1'b0} - 9'd1;
  assign span_prod   = {16'b0, odd_mult} * {9'b0, width_r[idx_r]};

  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      elapsed_r <= cur_elapsed;
      span_r    <= span_prod;
      dark_r    <= hold_dead || zero_cfg;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else if (cmd.tick) begin
      idx_r <= '0;
    end else if (cmd.next_led) begin
      idx_r <= idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mark_dark) begin
      levels_r[idx_r] <= 1'b0;
    end else if (cmd.mark_quo) begin
      levels_r[idx_r] <= ~div_quo[0];
    end
  end

  // phase = elapsed mod period, then phase / on width
  assign div_start    = cmd.div_mod || cmd.div_quo;
  assign div_dividend = cmd.div_mod ? elapsed_r : {div_rem, 16'b0};
  assign div_divisor  = cmd.div_mod ? period_r[idx_r] : width_r[idx_r];

  plfc_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .short_op  (cmd.div_quo),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .busy      (div_busy),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_levels_r <= levels_r ^ mask_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_pin_levels = out_levels_r;

  assign sts.dark     = dark_r;
  assign sts.gt_span  = {9'b0, div_rem} > span_r;
  assign sts.div_done = div_done;
  assign sts.last_led = idx_r == plfc_pkg::LED_IDX_W'(plfc_pkg::LED_NUM - 1);
  assign sts.out_free = !out_valid_r || !out_stall;

`ifndef NO_ASSERTIONS
  a_div_idle_on_start: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_busy)
    else $error("divider started while busy");

  a_mod_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_mod |-> (period_r[idx_r] != 16'd0))
    else $error("modulo by zero period");

  a_quo_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_quo |-> (width_r[idx_r] != 16'd0))
    else $error("divide by zero on width");

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!out_valid_r || !out_stall))
    else $error("result overwritten before taken");
`endif

endmodule

[rtl/plfc_ctrl.sv]
// plfc_ctrl: sequencing state machine, walks the leds one by one per tick
// and drives datapath commands; depends on plfc_pkg
module plfc_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic [1:0]          in_opcode,
  output logic                in_stall,
  input  plfc_pkg::plfc_sts_t sts,
  output plfc_pkg::plfc_cmd_t cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PREP  = 3'd1;
  localparam logic [2:0] S_CHECK = 3'd2;
  localparam logic [2:0] S_MODW  = 3'd3;
  localparam logic [2:0] S_QCHK  = 3'd4;
  localparam logic [2:0] S_QUOW  = 3'd5;
  localparam logic [2:0] S_NEXT  = 3'd6;
  localparam logic [2:0] S_OUT   = 3'd7;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = state_r != S_IDLE;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          case (in_opcode)
            plfc_pkg::OP_TICK: begin
              cmd.tick  = 1'b1;
              state_nxt = S_PREP;
            end
            plfc_pkg::OP_FLASH: cmd.flash = 1'b1;
            plfc_pkg::OP_OFF:   cmd.off   = 1'b1;
            default: ;
          endcase
        end
      end
      S_PREP: begin
        cmd.prep  = 1'b1;
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (sts.dark) begin
          cmd.mark_dark = 1'b1;
          state_nxt     = S_NEXT;
        end else begin
          cmd.div_mod = 1'b1;
          state_nxt   = S_MODW;
        end
      end
      S_MODW: begin
        if (sts.div_done) begin
          state_nxt = S_QCHK;
        end
      end
      S_QCHK: begin
        if (sts.gt_span) begin
          cmd.mark_dark = 1'b1;
          state_nxt     = S_NEXT;
        end else begin
          cmd.div_quo = 1'b1;
          state_nxt   = S_QUOW;
        end
      end
      S_QUOW: begin
        if (sts.div_done) begin
          cmd.mark_quo = 1'b1;
          state_nxt    = S_NEXT;
        end
      end
      S_NEXT: begin
        if (sts.last_led) begin
          state_nxt = S_OUT;
        end else begin
          cmd.next_led = 1'b1;
          state_nxt    = S_PREP;
        end
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

[rtl/priority_led_flash_controller_top.sv]
// priority_led_flash_controller_top: top level, joins controller and datapath
// depends on plfc_pkg, plfc_ctrl, plfc_dp
//
// usage
//   input channel (in_valid / in_stall): one beat is a tick, a flash request
//   or an off request. requests update the addressed led in the cycle they
//   are taken and give no result. a tick advances the time counter and
//   yields one beat on the result channel (out_valid / out_stall) with the
//   pin level of every led, polarity from the active-low mask applied.
//   cfg_wr_en / cfg_wr_data write the active-low mask; write only while idle.
//   evaluation: a request keeps in_stall low. a tick keeps in_stall
//   high while the leds are evaluated in turn by one shared serial divider
//   (32 steps for the period modulo, 16 for the pulse index): a dark led
//   skips the divider, a led whose phase lies past its pulses needs only
//   the modulo, and any other led needs both divisions. the result register
//   loads once the output is free; a new beat is taken in the next cycle.
//   reset clears time, all led settings and the result valid flag, and sets
//   the mask to 3'b100. a stalled result waits in the output register;
//   requests are still taken, and a following tick completes its
//   evaluation but holds until the previous result has been taken.
module priority_led_flash_controller_top (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [1:0]                   in_opcode,
  input  logic [3:0]                   in_led_select,
  input  logic [7:0]                   in_priority_req,
  input  logic [15:0]                  in_period,
  input  logic [15:0]                  in_on_width,
  input  logic [7:0]                   in_flash_count,
  input  logic [15:0]                  in_hold_time,
  input  logic                         cfg_wr_en,
  input  logic [plfc_pkg::LED_NUM-1:0] cfg_wr_data,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [plfc_pkg::LED_NUM-1:0] out_pin_levels
);

  plfc_pkg::plfc_cmd_t cmd;
  plfc_pkg::plfc_sts_t sts;

  plfc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_opcode (in_opcode),
    .in_stall  (in_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  plfc_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_led_select   (in_led_select),
    .in_priority_req (in_priority_req),
    .in_period       (in_period),
    .in_on_width     (in_on_width),
    .in_flash_count  (in_flash_count),
    .in_hold_time    (in_hold_time),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .out_pin_levels  (out_pin_levels)
  );

endmodule

[bench/plfc_level_checker.sv]
`timescale 1ns / 100ps
// plfc_level_checker: follows every beat of the priority led flash controller,
// keeps its own led settings, time count and polarity, checks each pin level
// beat in order; depends on plfc_pkg
module plfc_level_checker (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic                         in_stall,
  input  logic [1:0]                   in_opcode,
  input  logic [3:0]                   in_led_select,
  input  logic [7:0]                   in_priority_req,
  input  logic [15:0]                  in_period,
  input  logic [15:0]                  in_on_width,
  input  logic [7:0]                   in_flash_count,
  input  logic [15:0]                  in_hold_time,
  input  logic                         cfg_wr_en,
  input  logic [plfc_pkg::LED_NUM-1:0] cfg_wr_data,
  input  logic                         out_valid,
  input  logic                         out_stall,
  input  logic [plfc_pkg::LED_NUM-1:0] out_pin_levels,
  output int                           mismatch_count,
  output int                           levels_owed
);

  typedef struct packed {
    logic [31:0] start;
    logic [15:0] period;
    logic [15:0] width;
    logic [15:0] hold;
    logic [7:0]  prio;
    logic [7:0]  count;
  } led_state_t;

  led_state_t                   leds [plfc_pkg::LED_NUM];
  logic [31:0]                  now_units;
  logic [plfc_pkg::LED_NUM-1:0] polarity;
  logic [plfc_pkg::LED_NUM-1:0] due_levels [$];

  function automatic logic lit_at(input led_state_t s, input logic [31:0] t);
    logic [31:0] elapsed;
    logic [31:0] phase;
    logic [31:0] span;
    logic [31:0] pulse_no;
    elapsed = t - s.start;
    if (s.hold != plfc_pkg::FOREVER_CODE && elapsed > {16'd0, s.hold}) return 1'b0;
    if (s.count == 8'd0 || s.period == 16'd0 || s.width == 16'd0) return 1'b0;
    span = ({23'd0, s.count, 1'b0} - 32'd1) * {16'd0, s.width};
    phase = elapsed % {16'd0, s.period};
    if (phase > span) return 1'b0;
    pulse_no = phase / {16'd0, s.width};
    return ~pulse_no[0];
  endfunction

  function automatic logic [plfc_pkg::LED_NUM-1:0] predict_levels();
    logic [plfc_pkg::LED_NUM-1:0] lv;
    for (int i = 0; i < plfc_pkg::LED_NUM; i++) lv[i] = polarity[i] ^ lit_at(leds[i], now_units);
    return lv;
  endfunction

  always @(posedge clk) begin : watch
    logic [plfc_pkg::LED_NUM-1:0] want;
    int led;
    if (!rst_n) begin
      mismatch_count = 0;
      now_units = 32'd0;
      polarity = plfc_pkg::MASK_RESET;
      for (int i = 0; i < plfc_pkg::LED_NUM; i++) leds[i] = '0;
      due_levels.delete();
    end else begin
      if (cfg_wr_en) polarity = cfg_wr_data;
      if (out_valid && !out_stall) begin
        if (due_levels.size() == 0) begin
          mismatch_count++;
          $display("%0t: pin level beat %b with none expected", $time, out_pin_levels);
        end else begin
          want = due_levels.pop_front();
          if (want !== out_pin_levels) begin
            mismatch_count++;
            $display("%0t: pin levels expected %b got %b", $time, want, out_pin_levels);
          end
        end
      end
      if (in_valid && !in_stall) begin
        led = int'(in_led_select);
        case (in_opcode)
          plfc_pkg::OP_TICK: begin
            now_units = now_units + 32'd1;
            due_levels.push_back(predict_levels());
          end
          plfc_pkg::OP_FLASH: begin
            if (led < plfc_pkg::LED_NUM && in_priority_req >= leds[led].prio) begin
              leds[led].start  = now_units;
              leds[led].period = in_period;
              leds[led].width  = in_on_width;
              leds[led].count  = in_flash_count;
              leds[led].hold   = in_hold_time;
              leds[led].prio   = in_priority_req;
            end
          end
          plfc_pkg::OP_OFF: begin
            if (led < plfc_pkg::LED_NUM) begin
              leds[led].start  = 32'd0;
              leds[led].period = 16'd0;
              leds[led].width  = 16'd0;
              leds[led].hold   = 16'd0;
              leds[led].prio   = 8'd0;
            end
          end
          default: ;
        endcase
      end
    end
    levels_owed = due_levels.size();
  end

endmodule

[bench/tb_priority_led_flash_controller_top.sv]
`timescale 1ns / 100ps
// tb_priority_led_flash_controller_top: drives requests, ticks and polarity
// writes into the flash controller with random idling; depends on plfc_pkg,
// priority_led_flash_controller_top and plfc_level_checker
module tb_priority_led_flash_controller_top;

  localparam logic [1:0] OP_SPARE    = 2'd3;
  localparam int         HOLD_CYCLES = 700;
  localparam int         PHASE_BEATS = 267;

  logic                         clk;
  logic                         rst_n;
  logic                         in_valid;
  logic                         in_stall;
  logic [1:0]                   in_opcode;
  logic [3:0]                   in_led_select;
  logic [7:0]                   in_priority_req;
  logic [15:0]                  in_period;
  logic [15:0]                  in_on_width;
  logic [7:0]                   in_flash_count;
  logic [15:0]                  in_hold_time;
  logic                         cfg_wr_en;
  logic [plfc_pkg::LED_NUM-1:0] cfg_wr_data;
  logic                         out_valid;
  logic                         out_stall;
  logic [plfc_pkg::LED_NUM-1:0] out_pin_levels;
  int                           mismatch_count;
  int                           levels_owed;
  int                           tx_pct;
  int                           rx_pct;
  int                           hold_asks;

  priority_led_flash_controller_top u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_opcode      (in_opcode),
    .in_led_select  (in_led_select),
    .in_priority_req(in_priority_req),
    .in_period      (in_period),
    .in_on_width    (in_on_width),
    .in_flash_count (in_flash_count),
    .in_hold_time   (in_hold_time),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_pin_levels (out_pin_levels)
  );

  plfc_level_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_opcode      (in_opcode),
    .in_led_select  (in_led_select),
    .in_priority_req(in_priority_req),
    .in_period      (in_period),
    .in_on_width    (in_on_width),
    .in_flash_count (in_flash_count),
    .in_hold_time   (in_hold_time),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_pin_levels (out_pin_levels),
    .mismatch_count (mismatch_count),
    .levels_owed    (levels_owed)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic int pick_gap();
    if ($urandom_range(99) < 85) return int'($urandom_range(3, 1));
    return int'($urandom_range(60, 12));
  endfunction

  task automatic send_beat(input logic [1:0] op, input logic [3:0] sel,
                           input logic [7:0] prio, input logic [15:0] per,
                           input logic [15:0] w, input logic [7:0] cnt,
                           input logic [15:0] hold);
    int gap;
    gap = ($urandom_range(99) < tx_pct) ? pick_gap() : 0;
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid        <= 1'b1;
    in_opcode       <= op;
    in_led_select   <= sel;
    in_priority_req <= prio;
    in_period       <= per;
    in_on_width     <= w;
    in_flash_count  <= cnt;
    in_hold_time    <= hold;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic random_beat();
    logic [1:0]  op;
    logic [3:0]  sel;
    logic [7:0]  prio;
    logic [7:0]  cnt;
    logic [15:0] per;
    logic [15:0] w;
    logic [15:0] hold;
    int          roll;
    roll = int'($urandom_range(99));
    if (roll < 66) op = plfc_pkg::OP_TICK;
    else if (roll < 88) op = plfc_pkg::OP_FLASH;
    else if (roll < 97) op = plfc_pkg::OP_OFF;
    else op = OP_SPARE;
    if ($urandom_range(9) == 0) sel = 4'($urandom_range(15, 3));
    else sel = 4'($urandom_range(2));
    if ($urandom_range(4) == 0) prio = 8'($urandom);
    else prio = 8'($urandom_range(7));
    if (op != plfc_pkg::OP_FLASH || $urandom_range(3) == 0) begin
      per  = 16'($urandom);
      w    = 16'($urandom);
      cnt  = 8'($urandom);
      hold = 16'($urandom);
    end else begin
      per = 16'($urandom_range(40));
      w   = 16'($urandom_range(8));
      cnt = 8'($urandom_range(4));
      case ($urandom_range(2))
        0:       hold = plfc_pkg::FOREVER_CODE;
        1:       hold = 16'($urandom_range(300));
        default: hold = 16'($urandom);
      endcase
    end
    send_beat(op, sel, prio, per, w, cnt, hold);
  endtask

  // stop offering, wait for every level beat, then let the block go quiet
  task automatic settle(input int extra);
    @(negedge clk);
    in_valid <= 1'b0;
    while (levels_owed != 0) @(negedge clk);
    repeat (extra) @(negedge clk);
  endtask

  task automatic write_polarity(input logic [plfc_pkg::LED_NUM-1:0] value);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin : receiver
    int stall_run;
    int holds_done;
    out_stall = 1'b0;
    stall_run = 0;
    holds_done = 0;
    forever begin
      @(negedge clk);
      if (hold_asks != holds_done) begin
        holds_done = hold_asks;
        stall_run = HOLD_CYCLES;
      end
      if (stall_run > 0) begin
        out_stall <= 1'b1;
        stall_run--;
      end else if ($urandom_range(99) < rx_pct) begin
        out_stall <= 1'b1;
        stall_run = pick_gap() - 1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin : stimulus
    logic [plfc_pkg::LED_NUM-1:0] mask;
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_opcode       = plfc_pkg::OP_TICK;
    in_led_select   = 4'd0;
    in_priority_req = 8'd0;
    in_period       = 16'd0;
    in_on_width     = 16'd0;
    in_flash_count  = 8'd0;
    in_hold_time    = 16'd0;
    cfg_wr_en       = 1'b0;
    cfg_wr_data     = '0;
    tx_pct          = 0;
    rx_pct          = 25;
    hold_asks       = 0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // directed: reset state, a short pattern, rejects, zero fields, ignored beats
    send_beat(plfc_pkg::OP_TICK, 4'd0, 8'd0, 16'd0, 16'd0, 8'd0, 16'd0);
    send_beat(plfc_pkg::OP_FLASH, 4'd0, 8'd3, 16'd10, 16'd2, 8'd2, plfc_pkg::FOREVER_CODE);
    repeat (6) send_beat(plfc_pkg::OP_TICK, 4'd0, 8'd0, 16'd0, 16'd0, 8'd0, 16'd0);
    send_beat(plfc_pkg::OP_FLASH, 4'd0, 8'd1, 16'd3, 16'd1, 8'd1, plfc_pkg::FOREVER_CODE);
    send_beat(plfc_pkg::OP_FLASH, 4'd1, 8'hFF, 16'hFFFF, 16'hFFFF, 8'hFF, 16'd0);
    send_beat(plfc_pkg::OP_FLASH, 4'd2, 8'd0, 16'd0, 16'd5, 8'd1, plfc_pkg::FOREVER_CODE);
    send_beat(plfc_pkg::OP_TICK, 4'd0, 8'd0, 16'd0, 16'd0, 8'd0, 16'd0);
    send_beat(plfc_pkg::OP_FLASH, 4'd2, 8'd0, 16'd5, 16'd0, 8'd1, plfc_pkg::FOREVER_CODE);
    send_beat(plfc_pkg::OP_FLASH, 4'd1, 8'hFF, 16'd1, 16'd1, 8'd0, plfc_pkg::FOREVER_CODE);
    send_beat(plfc_pkg::OP_TICK, 4'd0, 8'd0, 16'd0, 16'd0, 8'd0, 16'd0);
    send_beat(plfc_pkg::OP_FLASH, 4'd3, 8'hFF, 16'd2, 16'd1, 8'd1, plfc_pkg::FOREVER_CODE);
    send_beat(plfc_pkg::OP_OFF, 4'd15, 8'd0, 16'd0, 16'd0, 8'd0, 16'd0);
    send_beat(OP_SPARE, 4'hF, 8'hFF, 16'hFFFF, 16'hFFFF, 8'hFF, 16'hFFFF);
    send_beat(plfc_pkg::OP_OFF, 4'd0, 8'd0, 16'd0, 16'd0, 8'd0, 16'd0);
    send_beat(plfc_pkg::OP_TICK, 4'd0, 8'd0, 16'd0, 16'd0, 8'd0, 16'd0);
    send_beat(plfc_pkg::OP_FLASH, 4'd2, 8'd9, 16'd4, 16'd1, 8'd1, 16'd3);
    repeat (3) send_beat(plfc_pkg::OP_TICK, 4'd0, 8'd0, 16'd0, 16'd0, 8'd0, 16'd0);
    send_beat(plfc_pkg::OP_OFF, 4'd1, 8'd0, 16'd0, 16'd0, 8'd0, 16'd0);
    send_beat(plfc_pkg::OP_TICK, 4'd0, 8'd0, 16'd0, 16'd0, 8'd0, 16'd0);

    for (int phase = 0; phase < 6; phase++) begin
      settle(170);
      case (phase)
        0:       mask = 3'b000;
        1:       mask = 3'b111;
        2:       mask = 3'b101;
        3:       mask = 3'b010;
        4:       mask = plfc_pkg::MASK_RESET;
        default: mask = 3'($urandom);
      endcase
      write_polarity(mask);
      tx_pct = (phase == 0) ? 0 : int'($urandom_range(40, 15));
      rx_pct = (phase == 0) ? 0 : int'($urandom_range(40, 15));
      // long receiver hold-off while beats keep coming
      if (phase == 1) hold_asks++;
      for (int n = 0; n < PHASE_BEATS; n++) begin
        if (phase == 3 && n == PHASE_BEATS / 2) settle(0);
        random_beat();
      end
    end

    settle(200);
    if (mismatch_count == 0) $display("tb_priority_led_flash_controller_top OK");
    else $display("tb_priority_led_flash_controller_top NOT OK");
    $finish;
  end

  initial begin : limit
    #40000000;
    $display("tb_priority_led_flash_controller_top NOT OK");
    $finish;
  end

endmodule

[filelist.f]
rtl/plfc_pkg.sv
rtl/plfc_div.sv
rtl/plfc_dp.sv
rtl/plfc_ctrl.sv
rtl/priority_led_flash_controller_top.sv
bench/plfc_level_checker.sv
bench/tb_priority_led_flash_controller_top.sv
